// ===== rtl/alignment_dp_cell_fill_core_macros.svh =====
// Assertion macros for the alignment cell fill block.
`ifndef ALIGNMENT_DP_CELL_FILL_CORE_MACROS_SVH
`define ALIGNMENT_DP_CELL_FILL_CORE_MACROS_SVH

// Checked at every rising clock edge, also while reset is held.
`define ADFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked outside reset only.
`define ADFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ===== rtl/adfc_pkg.sv =====
// ----------------------------------------------------------------------------
// adfc_pkg
// Shared types and constants of the alignment cell fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package adfc_pkg;

    localparam int SCORE_W = 24;

    // command codes
    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    // register indexes
    localparam logic [2:0] REG_GAP_OPEN   = 3'd0;
    localparam logic [2:0] REG_GAP_EXTEND = 3'd1;
    localparam logic [2:0] REG_MATCH      = 3'd2;
    localparam logic [2:0] REG_MISMATCH   = 3'd3;
    localparam logic [2:0] REG_LOCAL      = 3'd4;
    localparam logic [2:0] REG_FREE_ROWS  = 3'd5;
    localparam logic [2:0] REG_FREE_COLS  = 3'd6;
    localparam logic [2:0] REG_USE_TABLE  = 3'd7;

    // origin flags
    localparam logic [2:0] FROM_DIAG = 3'b001;
    localparam logic [2:0] FROM_LEFT = 3'b010;
    localparam logic [2:0] FROM_UP   = 3'b100;

    localparam logic [6:0] CHAR_BASE = 7'd65;

    typedef struct packed {
        logic              command;
        logic [9:0]        row;
        logic [9:0]        col;
        logic [6:0]        char_a;
        logic [6:0]        char_b;
        logic signed [7:0] table_value;
    } t_in;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score_main;
        logic signed [SCORE_W-1:0] score_left_gap;
        logic signed [SCORE_W-1:0] score_up_gap;
        logic [2:0]                flags_main;
        logic [2:0]                flags_left_gap;
        logic [2:0]                flags_up_gap;
    } t_out;

    // one line store entry: main, left gap, up gap
    typedef struct packed {
        logic signed [SCORE_W-1:0] main;
        logic signed [SCORE_W-1:0] left;
        logic signed [SCORE_W-1:0] up;
    } t_line;

    function automatic logic signed [SCORE_W-1:0] f_sat24(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd8388607;
        lo = -26'sd8388608;
        if (v > hi) begin
            f_sat24 = 24'sh7FFFFF;
        end else if (v < lo) begin
            f_sat24 = 24'sh800000;
        end else begin
            f_sat24 = v[SCORE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/alignment_dp_cell_fill_core.sv =====
// ----------------------------------------------------------------------------
// alignment_dp_cell_fill_core
// One cell of a global or local alignment score matrix per transaction.
// ----------------------------------------------------------------------------
// Cells arrive in row-major order; each input transaction yields exactly one
// output transaction. One cell is taken per clock while the output is not
// stalled and the table clear is done: the line stores (main, left gap, up
// gap kept side by side in one memory) are read at the left and upper column
// on accept, the cell is scored in the next cycle and written back as that
// result moves into the output register. A cell that reads the column the
// previous cell is writing in the same edge gets the value forwarded. Output
// valid (r_out_valid) is registered from r_s1_valid on each advance, so an
// output stall can hold it back. After reset the substitution table is
// cleared, one entry per cycle, over all ALPHABET*ALPHABET entries (676 at
// the default); input stall stays high for that time while configuration
// writes are taken as usual. A table write (command 1) is done on accept and returns an all-zero result.
`default_nettype none

module alignment_dp_cell_fill_core #(
    parameter int MAX_LEN   = 1023,
    parameter int MIN_SCORE = -4194304,
    parameter int ALPHABET  = 26
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input channel
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire adfc_pkg::t_in  i_in_data,
    // output channel
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output adfc_pkg::t_out      o_out_data,
    // configuration
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [4:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (MAX_LEN < 1) ? 1 : $clog2(MAX_LEN + 1);
    localparam int LD = MAX_LEN + 1;
    localparam int TD = ALPHABET * ALPHABET;
    localparam int TW = $clog2(TD);
    localparam int SW = adfc_pkg::SCORE_W;

    // ---------------- configuration registers ----------------
    logic signed [10:0] r_gap_open, r_gap_extend, r_match, r_mismatch;
    logic               r_local, r_free_rows, r_free_cols, r_use_table;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_open   <= 11'sd0;
            r_gap_extend <= -11'sd2;
            r_match      <= 11'sd1;
            r_mismatch   <= -11'sd1;
            r_local      <= 1'b0;
            r_free_rows  <= 1'b0;
            r_free_cols  <= 1'b0;
            r_use_table  <= 1'b0;
        end else if (cfg_we) begin
            case (paddr[4:2])
                adfc_pkg::REG_GAP_OPEN:   r_gap_open   <= pwdata[10:0];
                adfc_pkg::REG_GAP_EXTEND: r_gap_extend <= pwdata[10:0];
                adfc_pkg::REG_MATCH:      r_match      <= pwdata[10:0];
                adfc_pkg::REG_MISMATCH:   r_mismatch   <= pwdata[10:0];
                adfc_pkg::REG_LOCAL:      r_local      <= pwdata[0];
                adfc_pkg::REG_FREE_ROWS:  r_free_rows  <= pwdata[0];
                adfc_pkg::REG_FREE_COLS:  r_free_cols  <= pwdata[0];
                adfc_pkg::REG_USE_TABLE:  r_use_table  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            adfc_pkg::REG_GAP_OPEN:   prdata = 32'(r_gap_open);
            adfc_pkg::REG_GAP_EXTEND: prdata = 32'(r_gap_extend);
            adfc_pkg::REG_MATCH:      prdata = 32'(r_match);
            adfc_pkg::REG_MISMATCH:   prdata = 32'(r_mismatch);
            adfc_pkg::REG_LOCAL:      prdata = {31'd0, r_local};
            adfc_pkg::REG_FREE_ROWS:  prdata = {31'd0, r_free_rows};
            adfc_pkg::REG_FREE_COLS:  prdata = {31'd0, r_free_cols};
            adfc_pkg::REG_USE_TABLE:  prdata = {31'd0, r_use_table};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_s1_valid, r_out_valid, r_clr_busy;
    logic adv, accept;

    // pipeline moves when the output register is empty or being drained
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv || r_clr_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // ---------------- address decode on accept ----------------
    logic [AW-1:0] in_idx, in_li;
    logic [6:0]    da, db;
    logic          in_chars_ok;
    logic [TW-1:0] in_taddr;

    assign in_idx = (32'(i_in_data.col) > MAX_LEN) ? AW'(MAX_LEN) : AW'(i_in_data.col);
    assign in_li  = in_idx - AW'(1);
    assign da     = i_in_data.char_a - adfc_pkg::CHAR_BASE;
    assign db     = i_in_data.char_b - adfc_pkg::CHAR_BASE;
    assign in_chars_ok = (i_in_data.char_a >= adfc_pkg::CHAR_BASE) && (da < 7'(ALPHABET))
                      && (i_in_data.char_b >= adfc_pkg::CHAR_BASE) && (db < 7'(ALPHABET));
    assign in_taddr = TW'(da) * TW'(ALPHABET) + TW'(db);

    // ---------------- substitution table ----------------
    logic signed [7:0] tab_mem [TD];
    logic [TW-1:0]     r_clr_cnt;
    logic signed [7:0] r_tab_rd;
    logic              r_tab_ok;
    logic              tab_we;

    assign tab_we = accept && (i_in_data.command == adfc_pkg::CMD_TABLE) && in_chars_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + TW'(1);
            if (r_clr_cnt == TW'(TD - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // table writes and reads both happen on accept; a read in the same edge as a write gets the old entry
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            tab_mem[r_clr_cnt] <= 8'sd0;
        end else if (tab_we) begin
            tab_mem[in_taddr] <= i_in_data.table_value;
        end
        if (accept) begin
            r_tab_rd <= tab_mem[in_taddr];
            r_tab_ok <= in_chars_ok;
        end
    end

    // ---------------- line store ----------------
    adfc_pkg::t_line line_mem [LD];
    adfc_pkg::t_line r_rd_l, r_rd_u, r_fwd, wdata;
    logic            r_hit_l, r_hit_u;
    logic            wr_en;
    adfc_pkg::t_in   r_s1;
    logic [AW-1:0]   r_s1_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            line_mem[r_s1_idx] <= wdata;
        end
        if (accept) begin
            r_rd_l <= line_mem[in_li];
            r_rd_u <= line_mem[in_idx];
            // forward the entry written at this same edge
            r_fwd   <= wdata;
            r_hit_l <= wr_en && (r_s1_idx == in_li);
            r_hit_u <= wr_en && (r_s1_idx == in_idx);
            r_s1     <= i_in_data;
            r_s1_idx <= in_idx;
        end
    end

    // ---------------- cell scoring ----------------
    adfc_pkg::t_line   lft, upc;
    adfc_pkg::t_line   r_diag;
    adfc_pkg::t_out    res;
    logic signed [10:0] sub;
    logic signed [25:0] op, ex, opex, col_ex, row_ex;
    logic signed [SW-1:0] min_s;
    logic signed [SW-1:0] d0, d1, d2, l0, l1, l2, u0, u1, u2, ma, mb, mc;
    logic               affine, rowz, colz;

    assign lft    = r_hit_l ? r_fwd : r_rd_l;
    assign upc    = r_hit_u ? r_fwd : r_rd_u;
    assign affine = (r_gap_open != 11'sd0);
    assign rowz   = (r_s1.row == 10'd0);
    assign colz   = (r_s1.col == 10'd0);
    assign op     = 26'(r_gap_open);
    assign ex     = 26'(r_gap_extend);
    assign opex   = op + ex;
    assign col_ex = 26'($signed({1'b0, r_s1.col})) * ex;
    assign row_ex = 26'($signed({1'b0, r_s1.row})) * ex;
    assign min_s  = SW'(MIN_SCORE);

    always_comb begin
        if (r_use_table) begin
            sub = r_tab_ok ? 11'(r_tab_rd) : 11'sd0;
        end else begin
            sub = (r_s1.char_a == r_s1.char_b) ? r_match : r_mismatch;
        end
    end

    always_comb begin
        d0 = adfc_pkg::f_sat24(26'(sub) + 26'(r_diag.main));
        d1 = adfc_pkg::f_sat24(26'(sub) + 26'(r_diag.left));
        d2 = adfc_pkg::f_sat24(26'(sub) + 26'(r_diag.up));
        if (affine) begin
            l0 = adfc_pkg::f_sat24(26'(lft.main) + opex);
            l1 = adfc_pkg::f_sat24(26'(lft.left) + ex);
            l2 = adfc_pkg::f_sat24(26'(lft.up) + opex);
            u0 = adfc_pkg::f_sat24(26'(upc.main) + opex);
            u1 = adfc_pkg::f_sat24(26'(upc.left) + opex);
            u2 = adfc_pkg::f_sat24(26'(upc.up) + ex);
        end else begin
            // linear: diagonal, left and up candidates of the single score
            l0 = adfc_pkg::f_sat24(26'(lft.main) + ex);
            l1 = l0;
            l2 = l0;
            u0 = adfc_pkg::f_sat24(26'(upc.main) + ex);
            u1 = u0;
            u2 = u0;
        end
        ma = (d0 > d1) ? d0 : d1;
        ma = (ma > d2) ? ma : d2;
        mb = (l0 > l1) ? l0 : l1;
        mb = (mb > l2) ? mb : l2;
        mc = (u0 > u1) ? u0 : u1;
        mc = (mc > u2) ? mc : u2;
    end

    always_comb begin
        logic signed [SW-1:0] lin;
        res = '0;
        lin = '0;
        if (r_s1.command == adfc_pkg::CMD_TABLE) begin
            res = '0;
        end else if (rowz || colz) begin
            // border cells
            if (!affine) begin
                if (r_local || (rowz && colz)) begin
                    res.score_main = '0;
                end else if (rowz) begin
                    res.score_main = r_free_cols ? '0 : adfc_pkg::f_sat24(col_ex);
                    res.flags_main = adfc_pkg::FROM_LEFT;
                end else begin
                    res.score_main = r_free_rows ? '0 : adfc_pkg::f_sat24(row_ex);
                    res.flags_main = adfc_pkg::FROM_UP;
                end
            end else if (rowz && colz) begin
                res.score_left_gap = min_s;
                res.score_up_gap   = min_s;
            end else if (rowz) begin
                res.score_main     = r_local ? '0 : min_s;
                res.score_left_gap = r_free_cols ? '0 : adfc_pkg::f_sat24(op + col_ex);
                res.score_up_gap   = min_s;
                if (!r_local) begin
                    if (r_s1.col == 10'd1) res.flags_main     = adfc_pkg::FROM_LEFT;
                    else                   res.flags_left_gap = adfc_pkg::FROM_LEFT;
                end
            end else begin
                res.score_main     = r_local ? '0 : min_s;
                res.score_left_gap = min_s;
                res.score_up_gap   = r_free_rows ? '0 : adfc_pkg::f_sat24(op + row_ex);
                if (!r_local) begin
                    if (r_s1.row == 10'd1) res.flags_main   = adfc_pkg::FROM_UP;
                    else                   res.flags_up_gap = adfc_pkg::FROM_UP;
                end
            end
        end else if (!affine) begin
            lin = (d0 > l0) ? d0 : l0;
            lin = (lin > u0) ? lin : u0;
            if (r_local && (lin <= 0)) begin
                res.score_main = '0;
            end else begin
                res.score_main = lin;
                res.flags_main = {lin == u0, lin == l0, lin == d0};
            end
        end else begin
            if (r_local && (ma <= 0)) begin
                res.score_main = '0;
            end else begin
                res.score_main     = ma;
                res.flags_main     = {2'b00, ma == d0};
                res.flags_left_gap = {2'b00, ma == d1};
                res.flags_up_gap   = {2'b00, ma == d2};
            end
            res.score_left_gap = mb;
            res.score_up_gap   = mc;
            res.flags_main     = res.flags_main     | {mc == u0, mb == l0, 1'b0};
            res.flags_left_gap = res.flags_left_gap | {mc == u1, mb == l1, 1'b0};
            res.flags_up_gap   = res.flags_up_gap   | {mc == u2, mb == l2, 1'b0};
        end
    end

    assign wr_en      = adv && r_s1_valid && (r_s1.command == adfc_pkg::CMD_CELL);
    assign wdata.main = res.score_main;
    assign wdata.left = res.score_left_gap;
    assign wdata.up   = res.score_up_gap;

    // ---------------- pipeline control and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_diag      <= '0;
        end else begin
            if (adv) begin
                r_s1_valid  <= accept;
                r_out_valid <= r_s1_valid;
            end
            // the upper column of this cell is the diagonal of the next one
            if (wr_en) begin
                r_diag <= upc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            o_out_data <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adfc_checker.sv =====
// ----------------------------------------------------------------------------
// adfc_checker
// Port-level checks of the alignment cell fill block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alignment_dp_cell_fill_core_macros.svh"

module adfc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire adfc_pkg::t_out o_out_data,
    input wire                 pready
);

    `ADFC_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
    `ADFC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "output dropped")
    `ADFC_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_data), "output changed")
    `ADFC_ASSERT_ALWAYS(a_clear_after_rst, $past(!i_rst_n) |-> o_in_stall, "accepting during clear")
    `ADFC_ASSERT(a_out_from_in, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2), "spurious output")

endmodule

bind alignment_dp_cell_fill_core adfc_checker u_adfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the alignment cell fill core: streams small score matrices in
// row-major order, substitution table writes and scattered cells under
// linear, affine, local, free-gap and table settings, with random idling on
// both channels. Results are checked against an in-bench scorer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NUM_CELLS = 1300;
    localparam int CALM_AT   = 1150;
    localparam int DOG_LIMIT = 4000;
    localparam int ALPHA     = 26;
    localparam int LINE_MAX  = 1023;
    localparam longint FLOOR = -4194304;

    // ------------------------------------------------------------------
    // Cell scorer and result check
    // ------------------------------------------------------------------
    class cell_scores;
        longint gap_open, gap_ext, match_sc, mismatch_sc;
        bit     local_on, free_rows, free_cols, table_on;
        longint line_main [LINE_MAX+1];
        longint line_left [LINE_MAX+1];
        longint line_up   [LINE_MAX+1];
        longint ul_main, ul_left, ul_up;
        byte    sub_tbl [ALPHA*ALPHA];
        adfc_pkg::t_out pending [$];
        int     errors;

        function new();
            gap_open = 0; gap_ext = -2; match_sc = 1; mismatch_sc = -1;
            local_on = 0; free_rows = 0; free_cols = 0; table_on = 0;
            ul_main = 0; ul_left = 0; ul_up = 0;
            foreach (sub_tbl[i]) sub_tbl[i] = 0;
            foreach (line_main[i]) begin
                line_main[i] = 0; line_left[i] = 0; line_up[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                adfc_pkg::REG_GAP_OPEN:   gap_open    = longint'($signed(v[10:0]));
                adfc_pkg::REG_GAP_EXTEND: gap_ext     = longint'($signed(v[10:0]));
                adfc_pkg::REG_MATCH:      match_sc    = longint'($signed(v[10:0]));
                adfc_pkg::REG_MISMATCH:   mismatch_sc = longint'($signed(v[10:0]));
                adfc_pkg::REG_LOCAL:      local_on    = v[0];
                adfc_pkg::REG_FREE_ROWS:  free_rows   = v[0];
                adfc_pkg::REG_FREE_COLS:  free_cols   = v[0];
                adfc_pkg::REG_USE_TABLE:  table_on    = v[0];
                default: ;
            endcase
        endfunction

        function bit in_alpha(logic [6:0] ch);
            return ch >= adfc_pkg::CHAR_BASE && ch < adfc_pkg::CHAR_BASE + ALPHA;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        function longint top3(longint p, longint q, longint s);
            longint m;
            m = p > q ? p : q;
            return m > s ? m : s;
        endfunction

        function adfc_pkg::t_out score_cell(adfc_pkg::t_in x);
            adfc_pkg::t_out r;
            longint a, b, c, rw, cl, sub;
            longint d0, d1, d2, l0, l1, l2, u0, u1, u2;
            logic [2:0] fa, fb, fc;
            int     idx, li, ti;
            bit     affine;
            r = '0;
            if (x.command == adfc_pkg::CMD_TABLE) begin
                if (in_alpha(x.char_a) && in_alpha(x.char_b)) begin
                    ti = (int'(x.char_a) - int'(adfc_pkg::CHAR_BASE)) * ALPHA
                       + (int'(x.char_b) - int'(adfc_pkg::CHAR_BASE));
                    sub_tbl[ti] = x.table_value;
                end
                return r;
            end
            a = 0; b = 0; c = 0; fa = '0; fb = '0; fc = '0;
            rw = x.row; cl = x.col; idx = x.col;
            affine = gap_open != 0;
            if (rw == 0 || cl == 0) begin
                if (!affine) begin
                    if (local_on || (rw == 0 && cl == 0)) begin
                        a = 0;
                    end else if (rw == 0) begin
                        a = free_cols ? 0 : cl * gap_ext; fa = adfc_pkg::FROM_LEFT;
                    end else begin
                        a = free_rows ? 0 : rw * gap_ext; fa = adfc_pkg::FROM_UP;
                    end
                end else if (rw == 0 && cl == 0) begin
                    a = 0; b = FLOOR; c = FLOOR;
                end else if (rw == 0) begin
                    a = local_on ? 0 : FLOOR;
                    b = free_cols ? 0 : gap_open + gap_ext * cl;
                    c = FLOOR;
                    if (!local_on) begin
                        if (cl == 1) fa = adfc_pkg::FROM_LEFT;
                        else fb = adfc_pkg::FROM_LEFT;
                    end
                end else begin
                    a = local_on ? 0 : FLOOR;
                    b = FLOOR;
                    c = free_rows ? 0 : gap_open + gap_ext * rw;
                    if (!local_on) begin
                        if (rw == 1) fa = adfc_pkg::FROM_UP;
                        else fc = adfc_pkg::FROM_UP;
                    end
                end
            end else begin
                li = idx - 1;
                if (table_on) begin
                    if (in_alpha(x.char_a) && in_alpha(x.char_b)) begin
                        ti = (int'(x.char_a) - int'(adfc_pkg::CHAR_BASE)) * ALPHA
                           + (int'(x.char_b) - int'(adfc_pkg::CHAR_BASE));
                        sub = sub_tbl[ti];
                    end else begin
                        sub = 0;
                    end
                end else begin
                    sub = (x.char_a == x.char_b) ? match_sc : mismatch_sc;
                end
                if (!affine) begin
                    d0 = clip(sub + ul_main);
                    l0 = clip(gap_ext + line_main[li]);
                    u0 = clip(gap_ext + line_main[idx]);
                    a = top3(d0, l0, u0);
                    if (local_on && a <= 0) begin
                        a = 0;
                    end else begin
                        if (a == d0) fa |= adfc_pkg::FROM_DIAG;
                        if (a == l0) fa |= adfc_pkg::FROM_LEFT;
                        if (a == u0) fa |= adfc_pkg::FROM_UP;
                    end
                end else begin
                    d0 = clip(sub + ul_main);
                    d1 = clip(sub + ul_left);
                    d2 = clip(sub + ul_up);
                    l0 = clip(line_main[li] + gap_open + gap_ext);
                    l1 = clip(line_left[li] + gap_ext);
                    l2 = clip(line_up[li] + gap_open + gap_ext);
                    u0 = clip(line_main[idx] + gap_open + gap_ext);
                    u1 = clip(line_left[idx] + gap_open + gap_ext);
                    u2 = clip(line_up[idx] + gap_ext);
                    a = top3(d0, d1, d2);
                    if (local_on && a <= 0) begin
                        a = 0;
                    end else begin
                        if (a == d0) fa |= adfc_pkg::FROM_DIAG;
                        if (a == d1) fb |= adfc_pkg::FROM_DIAG;
                        if (a == d2) fc |= adfc_pkg::FROM_DIAG;
                    end
                    b = top3(l0, l1, l2);
                    if (b == l0) fa |= adfc_pkg::FROM_LEFT;
                    if (b == l1) fb |= adfc_pkg::FROM_LEFT;
                    if (b == l2) fc |= adfc_pkg::FROM_LEFT;
                    c = top3(u0, u1, u2);
                    if (c == u0) fa |= adfc_pkg::FROM_UP;
                    if (c == u1) fb |= adfc_pkg::FROM_UP;
                    if (c == u2) fc |= adfc_pkg::FROM_UP;
                end
            end
            a = clip(a); b = clip(b); c = clip(c);
            // upper-left of the next cell is this column's previous row
            ul_main = line_main[idx]; ul_left = line_left[idx]; ul_up = line_up[idx];
            line_main[idx] = a; line_left[idx] = b; line_up[idx] = c;
            r.score_main     = a[23:0];
            r.score_left_gap = b[23:0];
            r.score_up_gap   = c[23:0];
            r.flags_main     = fa;
            r.flags_left_gap = fb;
            r.flags_up_gap   = fc;
            return r;
        endfunction

        function void note_cell(adfc_pkg::t_in x);
            pending.push_back(score_cell(x));
        endfunction

        function void check_cell(adfc_pkg::t_out got);
            adfc_pkg::t_out want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: main exp %0d got %0d, left exp %0d got %0d",
                             want.score_main, got.score_main,
                             want.score_left_gap, got.score_left_gap);
                    $display("  up exp %0d got %0d, flags exp %b/%b/%b got %b/%b/%b",
                             want.score_up_gap, got.score_up_gap,
                             want.flags_main, want.flags_left_gap, want.flags_up_gap,
                             got.flags_main, got.flags_left_gap, got.flags_up_gap);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    adfc_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    adfc_pkg::t_out o_out_data;
    logic           psel        = 1'b0;
    logic           penable     = 1'b0;
    logic           pwrite      = 1'b0;
    logic [4:0]     paddr       = '0;
    logic [31:0]    pwdata      = '0;
    logic [31:0]    prdata;
    logic           pready;

    cell_scores sb = new();
    bit         calm = 1'b0;     // no idling in the last part of the run
    int         idle_pct = 10;   // idling chance per transaction, per phase
    int         cells_sent = 0;
    int         out_hold = 0;
    int         quiet_cycles = 0;
    bit         written [LINE_MAX+1];

    always #2 i_clk = ~i_clk;

    alignment_dp_cell_fill_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Output side: random stall bursts, result check, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold--;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            i_out_stall <= 1'b1;
            out_hold = $urandom_range(0, 14);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_cell(o_out_data);
    end

    // cycles with no transaction on either channel; covers the table clear
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= DOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);   // register written at this edge (pready high)
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic load_settings(int op, int ex, int ma, int mi,
                                 bit loc, bit fr, bit fcl, bit tbl);
        cfg_write(adfc_pkg::REG_GAP_OPEN,   32'(op));
        cfg_write(adfc_pkg::REG_GAP_EXTEND, 32'(ex));
        cfg_write(adfc_pkg::REG_MATCH,      32'(ma));
        cfg_write(adfc_pkg::REG_MISMATCH,   32'(mi));
        cfg_write(adfc_pkg::REG_LOCAL,      32'(loc));
        cfg_write(adfc_pkg::REG_FREE_ROWS,  32'(fr));
        cfg_write(adfc_pkg::REG_FREE_COLS,  32'(fcl));
        cfg_write(adfc_pkg::REG_USE_TABLE,  32'(tbl));
    endtask

    // one transaction on the input channel, with an optional idle burst first
    task automatic send(adfc_pkg::t_in x);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_cell(x);
        if (x.command == adfc_pkg::CMD_CELL) begin
            written[x.col] = 1'b1;
            cells_sent++;
        end
        if (cells_sent >= CALM_AT) calm = 1'b1;
    endtask

    task automatic send_cell(int r, int c, logic [6:0] ca, logic [6:0] cb);
        adfc_pkg::t_in x;
        x = '0;
        x.command = adfc_pkg::CMD_CELL;
        x.row = 10'(r); x.col = 10'(c);
        x.char_a = ca; x.char_b = cb;
        x.table_value = 8'($urandom);   // ignored for cells, toggled anyway
        send(x);
    endtask

    task automatic send_table(logic [6:0] ca, logic [6:0] cb, logic [7:0] v);
        adfc_pkg::t_in x;
        x = '0;
        x.command = adfc_pkg::CMD_TABLE;
        x.row = 10'($urandom); x.col = 10'($urandom);
        x.char_a = ca; x.char_b = cb; x.table_value = v;
        send(x);
        cells_sent++;
    endtask

    // mostly a narrow alphabet so matches are frequent; now and then any code
    function automatic logic [6:0] pick_char();
        if ($urandom_range(0, 29) == 0) return 7'($urandom);
        if ($urandom_range(0, 3) == 0) return 7'($urandom_range(65, 90));
        return 7'($urandom_range(65, 68));
    endfunction

    // full matrix, row-major, with table writes mixed in
    task automatic run_matrix(int rows, int cols);
        for (int r = 0; r <= rows; r++) begin
            for (int c = 0; c <= cols; c++) begin
                if ($urandom_range(0, 19) == 0)
                    send_table(pick_char(), pick_char(), 8'($urandom));
                send_cell(r, c, pick_char(), pick_char());
            end
        end
    endtask

    // scattered cell; interior only where both line store columns hold data
    task automatic stray_cell();
        int r, c;
        r = $urandom_range(0, 1023);
        c = $urandom_range(0, 1023);
        if (r != 0 && c != 0 && !(written[c] && written[c-1])) r = 0;
        send_cell(r, c, pick_char(), pick_char());
    endtask

    // wait for all results to arrive and for the pipeline to empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic int rand_weight();
        case ($urandom_range(0, 4))
            0: return -1024;
            1: return 1023;
            default: return $signed(11'($urandom)) / 16;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        foreach (written[i]) written[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // taken during the table clear; reset values, linear global scoring
        load_settings(0, -2, 1, -1, 0, 0, 0, 0);

        // directed: table extremes, ignored write, small matrix, far edges
        send_table(7'd65, 7'd65, 8'sd127);
        send_table(7'd90, 7'd90, -8'sd128);
        send_table(7'd65, 7'd90, 8'sd5);
        send_table(7'd127, 7'd65, 8'sd9);
        send_table(7'd0, 7'd0, 8'sd3);
        send_cell(0, 0, 7'd65, 7'd65);
        send_cell(0, 1, 7'd65, 7'd90);
        send_cell(0, 2, 7'd65, 7'd65);
        send_cell(1, 0, 7'd65, 7'd65);
        send_cell(1, 1, 7'd65, 7'd65);
        send_cell(1, 2, 7'd90, 7'd65);
        send_cell(0, 1021, 7'd65, 7'd65);
        send_cell(0, 1022, 7'd66, 7'd66);
        send_cell(0, 1023, 7'd67, 7'd67);
        send_cell(1, 1022, 7'd0, 7'd127);
        send_cell(1, 1023, 7'd127, 7'd127);
        send_cell(1023, 0, 7'd65, 7'd65);
        send_cell(1023, 1023, 7'd90, 7'd90);
        drain();

        phase = 0;
        while (cells_sent < NUM_CELLS) begin
            phase++;
            idle_pct = (phase % 4 == 0) ? 0 : $urandom_range(3, 25);
            case (phase)
                1: load_settings(-3, -1, 2, -1, 0, 0, 0, 0);
                2: load_settings(-5, -1, 0, 0, 1, 0, 0, 1);
                3: load_settings(0, -1, 2, -2, 1, 1, 1, 0);
                4: load_settings(-1024, -1024, 1023, -1024, 0, 1, 1, 0);
                5: load_settings(1023, 1023, -1024, 1023, 0, 0, 1, 1);
                6: load_settings(0, -1024, 1023, -1024, 0, 1, 0, 1);
                default: load_settings(($urandom_range(0, 3) == 0) ? 0 : rand_weight(),
                                       rand_weight(), rand_weight(), rand_weight(),
                                       1'($urandom), 1'($urandom), 1'($urandom),
                                       1'($urandom));
            endcase
            repeat (3) begin
                run_matrix($urandom_range(1, 6), $urandom_range(1, 9));
                repeat ($urandom_range(0, 4)) stray_cell();
            end
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
